// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the tag value extractor.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define XTV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define XTV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/xtv_pkg.sv =====
// Shared constants, types and state codes of the XML tag value extractor.
// No dependencies; every other design file but assert_macros.svh imports it.
package xtv_pkg;

   localparam int MAX_TAG_LEN       = 24;
   localparam int DEF_MAX_VALUE_LEN = 128;
   localparam int TAG_LEN_W         = 5;
   localparam int TIMEOUT_W         = 16;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 64;
   localparam int KIND_W            = 2;
   localparam int STATUS_W          = 2;
   localparam int COUNT_W           = 4;
   localparam int WORD_BYTES        = 8;
   localparam int WORD_W            = 64;

   localparam logic [7:0] CH_OPEN  = 8'h3C;
   localparam logic [7:0] CH_CLOSE = 8'h3E;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_FOUND   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLOSED  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TAG_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_MID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_LEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 3'd4;

   // Reset tag is "int".
   localparam logic [CSR_DATA_W-1:0] RST_TAG_LOW = 64'd7630441;
   localparam logic [TAG_LEN_W-1:0]  RST_TAG_LEN = 5'd3;
   localparam logic [TIMEOUT_W-1:0]  RST_TIMEOUT = 16'd2000;

   typedef struct packed {
      logic [MAX_TAG_LEN-1:0][7:0] tag_chars;
      logic [TAG_LEN_W-1:0]        tag_len;   // already clamped to MAX_TAG_LEN
      logic [TIMEOUT_W-1:0]        timeout;
   } cfg_type;

   typedef struct packed {
      logic start_emit;
      logic timed_out;
      logic closed;
   } scan_evt_type;

   typedef enum logic [1:0] {
      ST_SCAN,
      ST_READ,
      ST_SEND
   } emit_state_type;

endpackage

// ===== design/xtv_csr.sv =====
// Configuration registers of the tag value extractor: search tag, tag length, timeout.
// Depends on xtv_pkg.
module xtv_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [xtv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [xtv_pkg::CSR_DATA_W-1:0] csr_data,
   output xtv_pkg::cfg_type               cfg
);
   import xtv_pkg::*;

   logic [CSR_DATA_W-1:0] tag_low_ff, tag_low_in;
   logic [CSR_DATA_W-1:0] tag_mid_ff, tag_mid_in;
   logic [CSR_DATA_W-1:0] tag_high_ff, tag_high_in;
   logic [TAG_LEN_W-1:0]  tag_len_ff, tag_len_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;

   assign csr_ready = 1'b1;

   always_comb begin
      tag_low_in  = tag_low_ff;
      tag_mid_in  = tag_mid_ff;
      tag_high_in = tag_high_ff;
      tag_len_in  = tag_len_ff;
      timeout_in  = timeout_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TAG_LOW:  tag_low_in  = csr_data;
            CSR_TAG_MID:  tag_mid_in  = csr_data;
            CSR_TAG_HIGH: tag_high_in = csr_data;
            CSR_TAG_LEN:  tag_len_in  = csr_data[TAG_LEN_W-1:0];
            CSR_TIMEOUT:  timeout_in  = csr_data[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_low_ff  <= RST_TAG_LOW;
         tag_mid_ff  <= '0;
         tag_high_ff <= '0;
         tag_len_ff  <= RST_TAG_LEN;
         timeout_ff  <= RST_TIMEOUT;
      end else begin
         tag_low_ff  <= tag_low_in;
         tag_mid_ff  <= tag_mid_in;
         tag_high_ff <= tag_high_in;
         tag_len_ff  <= tag_len_in;
         timeout_ff  <= timeout_in;
      end
   end

   always_comb begin
      cfg.tag_chars = {tag_high_ff, tag_mid_ff, tag_low_ff};
      cfg.tag_len   = (tag_len_ff > TAG_LEN_W'(MAX_TAG_LEN)) ? TAG_LEN_W'(MAX_TAG_LEN)
                                                            : tag_len_ff;
      cfg.timeout   = timeout_ff;
   end

endmodule

// ===== design/xtv_value_mem.sv =====
// Value store: 64-bit rows written one byte lane at a time, read one row per cycle.
// Depends on xtv_pkg.
module xtv_value_mem #(
   parameter  int MAX_VALUE_LEN = xtv_pkg::DEF_MAX_VALUE_LEN,
   localparam int LEN_W         = $clog2(MAX_VALUE_LEN + 1),
   localparam int ROWS          = (MAX_VALUE_LEN + 7) / 8,
   localparam int ROW_W         = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [LEN_W-1:0]           wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic                       rd_en,
   input  logic [ROW_W-1:0]           rd_row,
   output logic [xtv_pkg::WORD_W-1:0] rd_data
);
   import xtv_pkg::*;

   logic [WORD_W-1:0] store_ff [ROWS];
   logic [WORD_W-1:0] rd_data_ff;
   logic [ROW_W-1:0]  wr_row;
   logic [2:0]        wr_lane;

   assign wr_row  = wr_addr[ROW_W+2:3];
   assign wr_lane = wr_addr[2:0];
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_row][{wr_lane, 3'b000} +: 8] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_row];
      end
   end

endmodule

// ===== design/xtv_scan.sv =====
// Byte scanner: tag name matching, value length, idle counting, store writes.
// Depends on xtv_pkg.
module xtv_scan #(
   parameter  int MAX_VALUE_LEN = xtv_pkg::DEF_MAX_VALUE_LEN,
   localparam int LEN_W         = $clog2(MAX_VALUE_LEN + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       rearm,
   input  logic [xtv_pkg::KIND_W-1:0] req_kind,
   input  logic [7:0]                 req_byte_value,
   input  xtv_pkg::cfg_type           cfg,
   output xtv_pkg::scan_evt_type      evt,
   output logic [LEN_W-1:0]           value_length,
   output logic                       wr_en
);
   import xtv_pkg::*;

   logic                 in_tag_ff, in_tag_in;
   logic                 in_value_ff, in_value_in;
   logic                 mismatch_ff, mismatch_in;
   logic [TAG_LEN_W-1:0] name_count_ff, name_count_in;
   logic [LEN_W-1:0]     value_length_ff, value_length_in;
   logic [TIMEOUT_W-1:0] idle_count_ff, idle_count_in;

   logic       is_byte, is_tick, is_close;
   logic       is_open_ch, is_close_ch, is_space;
   logic       store_ok, do_clear;
   logic [7:0] exp_char;

   assign value_length = value_length_ff;

   always_comb begin
      is_byte     = (req_kind == KIND_BYTE);
      is_tick     = (req_kind == KIND_TICK);
      is_close    = (req_kind == KIND_CLOSE);
      is_open_ch  = (req_byte_value == CH_OPEN);
      is_close_ch = (req_byte_value == CH_CLOSE);
      is_space    = (req_byte_value == CH_SPACE);
      exp_char    = (name_count_ff < TAG_LEN_W'(MAX_TAG_LEN)) ? cfg.tag_chars[name_count_ff]
                                                               : 8'h00;
      store_ok    = (value_length_ff < LEN_W'(MAX_VALUE_LEN));

      evt.start_emit = is_byte && is_open_ch && in_value_ff;
      evt.timed_out  = is_tick && (idle_count_ff >= cfg.timeout);
      evt.closed     = is_close;

      wr_en    = accept && is_byte && !is_open_ch && !is_close_ch && in_value_ff && store_ok;
      do_clear = rearm || (accept && (evt.timed_out || evt.closed));
   end

   always_comb begin
      in_tag_in       = in_tag_ff;
      in_value_in     = in_value_ff;
      mismatch_in     = mismatch_ff;
      name_count_in   = name_count_ff;
      value_length_in = value_length_ff;
      idle_count_in   = idle_count_ff;
      if (do_clear) begin
         in_tag_in       = 1'b0;
         in_value_in     = 1'b0;
         mismatch_in     = 1'b0;
         name_count_in   = '0;
         value_length_in = '0;
         idle_count_in   = '0;
      end else if (accept && is_tick) begin
         idle_count_in = idle_count_ff + TIMEOUT_W'(1);
      end else if (accept && is_byte) begin
         idle_count_in = '0;
         if (is_open_ch) begin
            // with a value open, the emission pass rearms at its end
            if (!in_value_ff) begin
               in_tag_in       = 1'b1;
               mismatch_in     = 1'b0;
               name_count_in   = '0;
               value_length_in = '0;
            end
         end else if (is_close_ch) begin
            if (!mismatch_ff && name_count_ff == cfg.tag_len) begin
               in_value_in = 1'b1;
            end
            in_tag_in = 1'b0;
         end else begin
            if (in_tag_ff) begin
               if (is_space || name_count_ff > cfg.tag_len) begin
                  in_tag_in = 1'b0;
               end else begin
                  if (name_count_ff >= cfg.tag_len || exp_char != req_byte_value) begin
                     mismatch_in = 1'b1;
                  end
                  name_count_in = name_count_ff + TAG_LEN_W'(1);
               end
            end
            if (in_value_ff) begin
               if (store_ok) begin
                  value_length_in = value_length_ff + LEN_W'(1);
               end else begin
                  // overflow drops the value and blocks re-arming until the next '<', timeout or close
                  in_value_in     = 1'b0;
                  mismatch_in     = 1'b1;
                  value_length_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff       <= 1'b0;
         in_value_ff     <= 1'b0;
         mismatch_ff     <= 1'b0;
         name_count_ff   <= '0;
         value_length_ff <= '0;
         idle_count_ff   <= '0;
      end else begin
         in_tag_ff       <= in_tag_in;
         in_value_ff     <= in_value_in;
         mismatch_ff     <= mismatch_in;
         name_count_ff   <= name_count_in;
         value_length_ff <= value_length_in;
         idle_count_ff   <= idle_count_in;
      end
   end

endmodule

// ===== design/xml_tag_value_extractor.sv =====
// Top level of the XML tag value extractor: scanner, value store, emission sequencer.
// Depends on xtv_pkg, xtv_csr, xtv_value_mem, xtv_scan.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_kind, req_byte_value
//   rsp      out        rsp_valid / rsp_ready  rsp_status, rsp_value_bytes, rsp_byte_count, rsp_last
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// Bytes and idle ticks are taken one per cycle while req_ready is high.
// A '<' that closes a value starts an emission: each result is one value store row read
// (ST_READ), then a load of the output register once rsp has room (ST_SEND); req_ready is low.
// A timeout or close result is held off while rsp is full or an emission runs.
// Reset clears all control state; the value store is not cleared.
module xml_tag_value_extractor #(
   parameter int MAX_VALUE_LEN = xtv_pkg::DEF_MAX_VALUE_LEN
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [xtv_pkg::KIND_W-1:0]     req_kind,
   input  logic [7:0]                     req_byte_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [xtv_pkg::STATUS_W-1:0]   rsp_status,
   output logic [xtv_pkg::WORD_W-1:0]     rsp_value_bytes,
   output logic [xtv_pkg::COUNT_W-1:0]    rsp_byte_count,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [xtv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [xtv_pkg::CSR_DATA_W-1:0] csr_data
);
   import xtv_pkg::*;

   localparam int LEN_W = $clog2(MAX_VALUE_LEN + 1);
   localparam int ROWS  = (MAX_VALUE_LEN + 7) / 8;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   cfg_type          cfg;
   scan_evt_type     evt;
   logic [LEN_W-1:0] value_length;
   logic             wr_en;
   logic             accept, rearm, rd_en, send, slot_free, load_status;
   logic [WORD_W-1:0] rd_data;

   emit_state_type   state_ff, state_in;
   logic [ROW_W-1:0] emit_row_ff, emit_row_in;

   logic [LEN_W-1:0]   emit_rem;
   logic [COUNT_W-1:0] emit_cnt;
   logic               emit_last;
   logic [WORD_W-1:0]  emit_word;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [WORD_W-1:0]   rsp_value_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;

   xtv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   xtv_scan #(.MAX_VALUE_LEN(MAX_VALUE_LEN)) u_scan (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .rearm          (rearm),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .cfg            (cfg),
      .evt            (evt),
      .value_length   (value_length),
      .wr_en          (wr_en)
   );

   xtv_value_mem #(.MAX_VALUE_LEN(MAX_VALUE_LEN)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (value_length),
      .wr_data (req_byte_value),
      .rd_en   (rd_en),
      .rd_row  (emit_row_ff),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Bytes still owed from the current row onward, and that row's byte count, last flag and masked word.
   always_comb begin
      emit_rem  = value_length - LEN_W'({emit_row_ff, 3'b000});
      emit_cnt  = (emit_rem >= LEN_W'(WORD_BYTES)) ? COUNT_W'(WORD_BYTES)
                                                   : emit_rem[COUNT_W-1:0];
      emit_last = (emit_rem <= LEN_W'(WORD_BYTES));
      for (int i = 0; i < WORD_BYTES; i++) begin
         emit_word[i*8 +: 8] = (COUNT_W'(i) < emit_cnt) ? rd_data[i*8 +: 8] : 8'h00;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SCAN: begin
            if (accept && evt.start_emit) state_in = ST_READ;
         end
         ST_READ: state_in = ST_SEND;
         ST_SEND: begin
            if (slot_free) state_in = emit_last ? ST_SCAN : ST_READ;
         end
         default: state_in = ST_SCAN;
      endcase
   end

   always_comb begin
      rd_en       = (state_ff == ST_READ);
      send        = (state_ff == ST_SEND) && slot_free;
      rearm       = send && emit_last;
      req_ready   = (state_ff == ST_SCAN) && (slot_free || !(evt.timed_out || evt.closed));
      load_status = accept && (evt.timed_out || evt.closed);
   end

   always_comb begin
      emit_row_in = emit_row_ff;
      if (accept && evt.start_emit) begin
         emit_row_in = '0;
      end else if (send && !emit_last) begin
         emit_row_in = emit_row_ff + ROW_W'(1);
      end
      if (send || load_status) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         emit_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         emit_row_ff  <= emit_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         rsp_status_ff <= STATUS_FOUND;
         rsp_value_ff  <= emit_word;
         rsp_count_ff  <= emit_cnt;
         rsp_last_ff   <= emit_last;
      end else if (load_status) begin
         rsp_status_ff <= evt.timed_out ? STATUS_TIMEOUT : STATUS_CLOSED;
         rsp_value_ff  <= '0;
         rsp_count_ff  <= '0;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_bytes = rsp_value_ff;
   assign rsp_byte_count  = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== design/xtv_checker.sv =====
// Port-level checker for the XML tag value extractor, bound to the top level.
// Depends on xtv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xtv_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [xtv_pkg::KIND_W-1:0]   req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [xtv_pkg::STATUS_W-1:0] rsp_status,
   input logic [xtv_pkg::WORD_W-1:0]   rsp_value_bytes,
   input logic [xtv_pkg::COUNT_W-1:0]  rsp_byte_count,
   input logic                         rsp_last
);
   import xtv_pkg::*;

   `XTV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_bytes) && $stable(rsp_byte_count) && $stable(rsp_last) && $stable(rsp_status), "rsp item changed while stalled")
   `XTV_ASSERT_IMPL(a_status_empty, clock, reset, rsp_valid && rsp_status != STATUS_FOUND, rsp_byte_count == '0 && rsp_value_bytes == '0 && rsp_last, "status item is not empty and final")
   `XTV_ASSERT_IMPL(a_full_unless_last, clock, reset, rsp_valid && !rsp_last, rsp_status == STATUS_FOUND && rsp_byte_count == COUNT_W'(WORD_BYTES), "non-final item is not a full value word")
   `XTV_ASSERT_NEXT(a_close_result, clock, reset, req_valid && req_ready && req_kind == KIND_CLOSE, rsp_valid && rsp_status == STATUS_CLOSED, "close item gave no closed status")
   `XTV_ASSERT_IMPL(a_close_needs_slot, clock, reset, req_ready && req_kind == KIND_CLOSE, !rsp_valid || rsp_ready, "close item taken while rsp is full")

endmodule

bind xml_tag_value_extractor xtv_checker u_xtv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_value_bytes (rsp_value_bytes),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_last        (rsp_last)
);
